>>> sv/rsdz_pkg.sv
`default_nettype none
package rsdz_pkg;

	// Field widths
	localparam int AXIS_W = 16;
	localparam int CFG_W = 16;
	localparam int OUT_W = 17;

	// Derived widths
	localparam int MAG_W = AXIS_W;
	localparam int SUM_W = 2 * AXIS_W;
	localparam int ROOT_W = AXIS_W;
	localparam int SQ_STEPS = ROOT_W;
	localparam int UNITY_SH = 15;
	localparam int NUM_W = CFG_W + UNITY_SH;
	localparam int DEN_W = CFG_W + ROOT_W;
	localparam int DVD_W = MAG_W + NUM_W;
	localparam int Q_W = OUT_W;
	localparam int DSH_W = DEN_W + Q_W - 1;
	localparam int REM_W = (DVD_W > DSH_W) ? DVD_W : DSH_W;
	localparam int CMP_W = (ROOT_W > CFG_W) ? ROOT_W : CFG_W;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
	localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 16'd8000;
	localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd30000;

	// Square root cell payload
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] root;
		logic [SUM_W-1:0] bitv;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             sx;
		logic             sy;
	} sq_t;

	// Divider cell payload
	typedef struct packed {
		logic [REM_W-1:0] rem_x;
		logic [REM_W-1:0] rem_y;
		logic [REM_W-1:0] dsh;
		logic [Q_W-1:0]   qx;
		logic [Q_W-1:0]   qy;
		logic             sx;
		logic             sy;
		logic             centred;
		logic             zero;
	} div_t;

endpackage
`default_nettype wire

>>> sv/rsdz_sqrt_cell.sv
`default_nettype none
module rsdz_sqrt_cell
	import rsdz_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  sq_t  in_data,
	output logic out_valid,
	output sq_t  out_data
);

	logic [SUM_W:0] trial;
	logic           ge;
	sq_t            nxt;

	// One digit of the square root: try root + bit against the remainder
	always_comb begin
		trial = {1'b0, in_data.root} + {1'b0, in_data.bitv};
		ge = {1'b0, in_data.rem} >= trial;
		nxt = in_data;
		nxt.bitv = in_data.bitv >> 2;
		if (ge) begin
			nxt.rem = in_data.rem - trial[SUM_W-1:0];
			nxt.root = (in_data.root >> 1) + in_data.bitv;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule
`default_nettype wire

>>> sv/rsdz_div_cell.sv
`default_nettype none
module rsdz_div_cell
	import rsdz_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	logic ge_x;
	logic ge_y;
	div_t nxt;

	// One quotient bit per axis against the shared shifted divisor
	always_comb begin
		ge_x = in_data.rem_x >= in_data.dsh;
		ge_y = in_data.rem_y >= in_data.dsh;
		nxt = in_data;
		nxt.rem_x = ge_x ? in_data.rem_x - in_data.dsh : in_data.rem_x;
		nxt.rem_y = ge_y ? in_data.rem_y - in_data.dsh : in_data.rem_y;
		nxt.qx = {in_data.qx[Q_W-2:0], ge_x};
		nxt.qy = {in_data.qy[Q_W-2:0], ge_y};
		nxt.dsh = in_data.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule
`default_nettype wire

>>> sv/radial_stick_dead_zone.sv
`default_nettype none
// Radial dead zone for one two-axis stick sample.
// Input: a sample (x_in, y_in) transfers on a rising edge with start high and
// busy low. busy is always low: the pipeline takes a new sample every cycle.
// Output: each result shows on x_out, y_out, centred for one cycle with done
// high, in sample order. One result per cycle is sustained; the receiver
// cannot stall and needs none.
// The pipeline is a chain: 3 stages of magnitude and squaring, 16 square
// root cells (one root bit each), 2 stages of scaling and multiply, 17 divider
// cells (one quotient bit each) and the output register.
// Configuration: cfg_valid/cfg_ready write dead_zone (index 0) or full_scale
// (index 1) from cfg_data; other indexes are ignored. cfg_ready is always high.
// Write only while no sample is in flight.
// Reset: arst_n clears all valid bits (no result pending) and loads
// dead_zone = 8000, full_scale = 30000.
// Outputs are fixed point with 32768 = 1.0; centred flags a length inside
// the dead zone, where both outputs read zero.
module radial_stick_dead_zone
	import rsdz_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire  signed [AXIS_W-1:0]   x_in,
	input  wire  signed [AXIS_W-1:0]   y_in,
	output logic                       done,
	output logic signed [OUT_W-1:0]    x_out,
	output logic signed [OUT_W-1:0]    y_out,
	output logic                       centred,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire         [CFG_IDX_W-1:0] cfg_index,
	input  wire         [CFG_W-1:0]    cfg_data
);

	logic [CFG_W-1:0] dz_q;
	logic [CFG_W-1:0] fs_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DEAD_ZONE_RST;
			fs_q <= FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEAD_ZONE:  dz_q <= cfg_data;
				REG_FULL_SCALE: fs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: signs and magnitudes
	logic             v_s1, v_s2, v_s3;
	logic             sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [MAG_W-1:0] mx_s1, my_s1, mx_s2, my_s2, mx_s3, my_s3;
	logic [SUM_W-1:0] qx_s2, qy_s2, sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1 <= x_in[AXIS_W-1];
		sy_s1 <= y_in[AXIS_W-1];
		mx_s1 <= x_in[AXIS_W-1] ? MAG_W'(-x_in) : MAG_W'(x_in);
		my_s1 <= y_in[AXIS_W-1] ? MAG_W'(-y_in) : MAG_W'(y_in);
		// Stage 2: squares
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		mx_s2 <= mx_s1;
		my_s2 <= my_s1;
		qx_s2 <= SUM_W'(mx_s1) * SUM_W'(mx_s1);
		qy_s2 <= SUM_W'(my_s1) * SUM_W'(my_s1);
		// Stage 3: sum of squares
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		mx_s3 <= mx_s2;
		my_s3 <= my_s2;
		sum_s3 <= qx_s2 + qy_s2;
	end

	// Square root chain, one result bit per cell
	logic sq_v [SQ_STEPS+1];
	sq_t  sq_d [SQ_STEPS+1];

	assign sq_v[0] = v_s3;
	assign sq_d[0] = {sum_s3, SUM_W'(0), SUM_W'(1) << (SUM_W - 2), mx_s3, my_s3,
		sx_s3, sy_s3};

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		rsdz_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[i]),
			.in_data  (sq_d[i]),
			.out_valid(sq_v[i+1]),
			.out_data (sq_d[i+1])
		);
	end

	// Stage P1: dead zone test, clamp and scale factors
	logic [ROOT_W-1:0] len;
	logic [CMP_W-1:0]  len_e, dz_e, diff, span_e;
	logic [CFG_W-1:0]  span, n_eff, den_a;
	logic              cen, wide;

	always_comb begin
		len = sq_d[SQ_STEPS].root[ROOT_W-1:0];
		len_e = CMP_W'(len);
		dz_e = CMP_W'(dz_q);
		cen = len_e < dz_e;
		wide = fs_q > dz_q;
		span = fs_q - dz_q;
		span_e = CMP_W'(span);
		diff = len_e - dz_e;
		if (wide) begin
			n_eff = (diff > span_e) ? span : diff[CFG_W-1:0];
			den_a = span;
		end else begin
			n_eff = CFG_W'(1);
			den_a = CFG_W'(1);
		end
	end

	logic              v_p1, v_p2;
	logic [CFG_W-1:0]  n_p1, da_p1;
	logic [ROOT_W-1:0] len_p1;
	logic [MAG_W-1:0]  mx_p1, my_p1;
	logic              sx_p1, sy_p1, cen_p1, sx_p2, sy_p2, cen_p2;
	logic [DVD_W-1:0]  dx_p2, dy_p2;
	logic [DEN_W-1:0]  den_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else begin
			v_p1 <= sq_v[SQ_STEPS];
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		n_p1 <= n_eff;
		da_p1 <= den_a;
		len_p1 <= len;
		mx_p1 <= sq_d[SQ_STEPS].mag_x;
		my_p1 <= sq_d[SQ_STEPS].mag_y;
		sx_p1 <= sq_d[SQ_STEPS].sx;
		sy_p1 <= sq_d[SQ_STEPS].sy;
		cen_p1 <= cen;
		// Stage P2: dividends and divisor
		dx_p2 <= DVD_W'(SUM_W'(mx_p1) * SUM_W'(n_p1)) << UNITY_SH;
		dy_p2 <= DVD_W'(SUM_W'(my_p1) * SUM_W'(n_p1)) << UNITY_SH;
		den_p2 <= DEN_W'(da_p1) * DEN_W'(len_p1);
		sx_p2 <= sx_p1;
		sy_p2 <= sy_p1;
		cen_p2 <= cen_p1;
	end

	// Divider chain, one quotient bit per cell
	logic dv_v [Q_W+1];
	div_t dv_d [Q_W+1];

	assign dv_v[0] = v_p2;
	assign dv_d[0] = {REM_W'(dx_p2), REM_W'(dy_p2), REM_W'(den_p2) << (Q_W - 1),
		Q_W'(0), Q_W'(0), sx_p2, sy_p2, cen_p2, den_p2 == '0};

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		rsdz_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[j]),
			.in_data  (dv_d[j]),
			.out_valid(dv_v[j+1]),
			.out_data (dv_d[j+1])
		);
	end

	// Output register: restore signs, zero inside the dead zone or for a zero divisor
	logic             kill;
	logic [OUT_W-1:0] rx, ry;

	always_comb begin
		kill = dv_d[Q_W].centred || dv_d[Q_W].zero;
		rx = dv_d[Q_W].sx ? OUT_W'(-dv_d[Q_W].qx) : dv_d[Q_W].qx;
		ry = dv_d[Q_W].sy ? OUT_W'(-dv_d[Q_W].qy) : dv_d[Q_W].qy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		x_out <= kill ? '0 : signed'(rx);
		y_out <= kill ? '0 : signed'(ry);
		centred <= dv_d[Q_W].centred;
	end

endmodule
`default_nettype wire

>>> tb/sv/radial_stick_dead_zone_tb.sv
`default_nettype none
module radial_stick_dead_zone_tb;
	import rsdz_pkg::*;

	// Indexes that the block ignores
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int PIPE_DRAIN = 60;

	typedef struct {
		logic signed [OUT_W-1:0] x_val;
		logic signed [OUT_W-1:0] y_val;
		logic                    centred;
	} stick_result_t;

	// Radial dead zone predictor and expected-result queue
	class dead_zone_scoreboard;
		logic [CFG_W-1:0] dead_zone;
		logic [CFG_W-1:0] full_scale;
		stick_result_t    pending[$];
		int               errors;

		function new();
			dead_zone = DEAD_ZONE_RST;
			full_scale = FULL_SCALE_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_DEAD_ZONE)
				dead_zone = data;
			else if (idx == REG_FULL_SCALE)
				full_scale = data;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root;
			longint unsigned b;
			root = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v = v - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function logic signed [OUT_W-1:0] scale(longint v, longint unsigned num,
				longint unsigned den);
			longint unsigned mag;
			longint unsigned q;
			mag = (v < 0) ? longint'(-v) : longint'(v);
			if (den == 0)
				return '0;
			q = (mag * num) / den;
			if (v < 0)
				q = 64'd0 - q;
			return q[OUT_W-1:0];
		endfunction

		// Work out the result of one accepted sample
		function void note_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y);
			longint          sx;
			longint          sy;
			longint unsigned len;
			longint unsigned span;
			longint unsigned n;
			longint unsigned num;
			longint unsigned den;
			stick_result_t   r;
			sx = x;
			sy = y;
			len = int_sqrt(longint'(sx * sx + sy * sy));
			if (len < dead_zone) begin
				r.x_val = '0;
				r.y_val = '0;
				r.centred = 1'b1;
			end else begin
				if (full_scale > dead_zone) begin
					span = full_scale - dead_zone;
					n = len - dead_zone;
					if (n > span)
						n = span;
					num = n * 32768;
					den = span * len;
				end else begin
					num = 32768;
					den = len;
				end
				r.x_val = scale(sx, num, den);
				r.y_val = scale(sy, num, den);
				r.centred = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [OUT_W-1:0] xo, logic signed [OUT_W-1:0] yo,
				logic c);
			stick_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d centred=%0b", $time, xo, yo, c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (xo !== e.x_val) begin
				$display("%0t: x_out expected %0d actual %0d", $time, e.x_val, xo);
				errors++;
			end
			if (yo !== e.y_val) begin
				$display("%0t: y_out expected %0d actual %0d", $time, e.y_val, yo);
				errors++;
			end
			if (c !== e.centred) begin
				$display("%0t: centred expected %0b actual %0b", $time, e.centred, c);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic signed [AXIS_W-1:0] x_in = '0;
	logic signed [AXIS_W-1:0] y_in = '0;
	logic                     done;
	logic signed [OUT_W-1:0]  x_out;
	logic signed [OUT_W-1:0]  y_out;
	logic                     centred;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     no_gaps = 1'b0;
	dead_zone_scoreboard      sb = new();

	always #2 clk = ~clk;

	radial_stick_dead_zone i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_in(x_in), .y_in(y_in), .done(done), .x_out(x_out), .y_out(y_out),
		.centred(centred), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Observe transfers at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(x_out, y_out, centred);
			if (start && !busy)
				sb.note_sample(x_in, y_in);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y);
		while (!no_gaps && $urandom_range(99) < 35) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		x_in = x;
		y_in = y;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let the pipeline empty before touching registers
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic directed_samples();
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, 16'sd0);
		send_sample(16'sd0, -16'sd32768);
		send_sample(16'sd1, -16'sd1);
		send_sample(16'sd7999, 16'sd0);
		send_sample(16'sd8000, 16'sd0);
		send_sample(16'sd0, -16'sd30000);
		send_sample(16'sd21213, 16'sd21213);
		send_sample(-16'sd5657, 16'sd5657);
	endtask

	task automatic random_samples(int count);
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		int                       mode;
		int                       r;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(3);
			case (mode)
				0: begin
					x = AXIS_W'($urandom);
					y = AXIS_W'($urandom);
				end
				1: begin
					// around the dead zone edge
					r = int'(sb.dead_zone) + $urandom_range(8) - 4;
					if (r > 32767) r = 32767;
					if (r < 0) r = 0;
					x = $urandom_range(1) ? AXIS_W'(r) : AXIS_W'(-r);
					y = AXIS_W'($urandom_range(3)) - 16'sd1;
				end
				2: begin
					x = $signed(16'($urandom_range(2047))) - 16'sd1024;
					y = $signed(16'($urandom_range(2047))) - 16'sd1024;
				end
				default: begin
					x = $urandom_range(1) ? -16'sd32768 : 16'sd32767;
					y = AXIS_W'($urandom);
				end
			endcase
			send_sample(x, y);
		end
	endtask

	task automatic run_phase(logic [CFG_W-1:0] dz, logic [CFG_W-1:0] fs, int count);
		drain();
		write_reg(REG_DEAD_ZONE, dz);
		write_reg(REG_FULL_SCALE, fs);
		directed_samples();
		random_samples(count);
	endtask

	// Stimulus
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_samples();
		random_samples(150);
		no_gaps = 1'b1;
		random_samples(150);
		no_gaps = 1'b0;
		drain();
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h0000);
		random_samples(40);
		run_phase(16'd0, 16'd1, 130);
		run_phase(16'd0, 16'd0, 130);
		run_phase(16'hFFFF, 16'hFFFF, 100);
		run_phase(16'd46341, 16'd1, 100);
		run_phase(16'd100, 16'd46341, 130);
		run_phase(16'd1000, 16'd50, 130);
		run_phase(16'd0, 16'd46341, 130);
		run_phase(16'd46340, 16'd46341, 100);
		run_phase(16'($urandom_range(20000)), 16'($urandom_range(46341, 1)), 130);
		run_phase(16'd8000, 16'd30000, 130);
		drain();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
